/* design/modbus_rtu_register_slave_unit_defines.svh */
// assertion macros for the modbus rtu register slave
`ifndef MODBUS_RTU_REGISTER_SLAVE_UNIT_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mrs_pkg.sv */
// shared types, constants and the crc helper for the modbus rtu register slave
package mrs_pkg;

    localparam int MRS_TABLE_DEPTH = 64;
    localparam int MRS_MAX_READ    = 29;
    localparam int MRS_CFG_IDX_W   = 1;
    localparam int MRS_CFG_DATA_W  = 8;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [MRS_CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 1'd0;
    localparam logic [MRS_CFG_IDX_W-1:0] CFG_ENTRIES    = 1'd1;

    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_EXC_FLAG     = 8'h80;
    localparam logic [7:0] BYTE_MASK       = 8'hFF;

    localparam logic [7:0] EXC_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ADDR  = 8'h02;
    localparam logic [7:0] EXC_VALUE = 8'h03;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [5:0]  entry_index;
        logic [15:0] entry_value;
        logic        entry_readable;
        logic        entry_writable;
        logic [15:0] entry_low;
        logic [15:0] entry_high;
    } mrs_req_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] value_out;
    } mrs_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOST_OUT,
        ST_FE_CHECK,
        ST_DECIDE,
        ST_HDR,
        ST_DATA_HI,
        ST_DATA_LO,
        ST_CRC_LO,
        ST_CRC_HI
    } mrs_state_t;

    typedef enum logic [1:0] {
        RK_EXC,
        RK_READ,
        RK_WRITE
    } mrs_reply_t;

    typedef struct packed {
        logic frame_byte;
        logic load;
        logic host_rd;
        logic attr_rd;
        logic decide;
        logic emit_hdr;
        logic emit_hi;
        logic emit_lo;
        logic emit_crc_lo;
        logic emit_crc_hi;
        logic emit_host;
        logic clear_frame;
    } mrs_cmd_t;

    typedef struct packed {
        logic silent;
        logic is_read;
        logic hdr_last;
        logic regs_last;
    } mrs_status_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* design/mrs_ram.sv */
// generic single write port ram with registered read
module mrs_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/mrs_ctrl.sv */
// frame and reply sequencer for the modbus rtu register slave
module mrs_ctrl
    import mrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  op,
    input  logic        frame_end,
    input  mrs_status_t status,
    output mrs_cmd_t    cmd,
    output logic        busy,
    output logic        result_valid
);

    mrs_state_t state_reg, state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_FRAME && frame_end)
                begin
                    state_next = ST_FE_CHECK;
                end
                else if (accept && op == OP_READ)
                begin
                    state_next = ST_HOST_OUT;
                end
            end
            ST_HOST_OUT: state_next = ST_IDLE;
            ST_FE_CHECK: state_next = status.silent ? ST_IDLE : ST_DECIDE;
            ST_DECIDE:   state_next = ST_HDR;
            ST_HDR:
            begin
                if (status.hdr_last)
                begin
                    state_next = status.is_read ? ST_DATA_HI : ST_CRC_LO;
                end
            end
            ST_DATA_HI:  state_next = ST_DATA_LO;
            ST_DATA_LO:  state_next = status.regs_last ? ST_CRC_LO : ST_DATA_HI;
            ST_CRC_LO:   state_next = ST_CRC_HI;
            ST_CRC_HI:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.frame_byte = accept && op == OP_FRAME;
                cmd.load       = accept && op == OP_LOAD;
                cmd.host_rd    = accept && op == OP_READ;
            end
            ST_HOST_OUT: cmd.emit_host = 1'b1;
            ST_FE_CHECK:
            begin
                cmd.attr_rd     = 1'b1;
                cmd.clear_frame = status.silent;
            end
            ST_DECIDE:   cmd.decide = 1'b1;
            ST_HDR:      cmd.emit_hdr = 1'b1;
            ST_DATA_HI:  cmd.emit_hi = 1'b1;
            ST_DATA_LO:  cmd.emit_lo = 1'b1;
            ST_CRC_LO:   cmd.emit_crc_lo = 1'b1;
            ST_CRC_HI:
            begin
                cmd.emit_crc_hi = 1'b1;
                cmd.clear_frame = 1'b1;
            end
            default:     cmd = '0;
        endcase
    end

    assign result_valid = cmd.emit_host || cmd.emit_hdr || cmd.emit_hi || cmd.emit_lo
                       || cmd.emit_crc_lo || cmd.emit_crc_hi;

endmodule

/* design/mrs_dp.sv */
// frame capture, register table and reply byte datapath
module mrs_dp
    import mrs_pkg::*;
#(
    parameter int TABLE_DEPTH = MRS_TABLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mrs_cmd_t                  cmd,
    input  mrs_req_t                  req,
    input  logic                      cfg_we,
    input  logic [MRS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [MRS_CFG_DATA_W-1:0] cfg_data,
    output mrs_status_t               status,
    output mrs_rsp_t                  rsp
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ATTR_W = 34;

    logic [7:0]  slave_addr_reg;
    logic [6:0]  entries_reg;
    logic [3:0]  count_reg;
    logic [15:0] crc_reg;
    logic [7:0]  head_reg [6];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic        attr_valid_reg;
    logic        host_oob_reg;
    mrs_reply_t  kind_reg, kind_next;
    logic [7:0]  code_reg, code_next;
    logic [2:0]  hdr_ptr_reg;
    logic [4:0]  reg_ptr_reg;
    logic [15:0] tx_crc_reg;

    logic [15:0] addr16, arg16, idx16, lim17_src;
    logic [16:0] lim17, end17;
    logic [AW-1:0] idx_a, addr_a, rd_off, val_raddr, val_waddr;
    logic        idx_ok;
    logic [15:0] val_rdata, val_wdata;
    logic        val_we, val_re;
    logic [ATTR_W-1:0] attr_rdata;
    logic        a_rd, a_wr;
    logic [15:0] a_low, a_high;
    logic [7:0]  hdr_byte, tx_byte;
    logic [2:0]  hdr_len;
    logic [4:0]  nregs;

    assign addr16 = {head_reg[2], head_reg[3]};
    assign arg16  = {head_reg[4], head_reg[5]};
    assign idx16  = 16'(req.entry_index);
    assign idx_a  = idx16[AW-1:0];
    assign idx_ok = idx16 < 16'(TABLE_DEPTH);
    assign addr_a = addr16[AW-1:0];
    assign nregs  = arg16[4:0];
    assign lim17_src = 16'(entries_reg);
    assign lim17  = (lim17_src < 16'(TABLE_DEPTH)) ? {1'b0, lim17_src} : 17'(TABLE_DEPTH);
    assign end17  = {1'b0, addr16} + {1'b0, arg16};
    assign {a_rd, a_wr, a_low, a_high} = attr_rdata;

    // reply classification
    always_comb
    begin
        kind_next = RK_EXC;
        code_next = EXC_FUNC;
        if (head_reg[1] == FN_READ_HOLDING)
        begin
            if ({1'b0, addr16} >= lim17)
            begin
                code_next = EXC_ADDR;
            end
            else if (arg16 == 16'd0 || arg16 > 16'(MRS_MAX_READ))
            begin
                code_next = EXC_VALUE;
            end
            else if (end17 > lim17)
            begin
                code_next = EXC_ADDR;
            end
            else if (!(attr_valid_reg && a_rd))
            begin
                code_next = EXC_VALUE;
            end
            else
            begin
                kind_next = RK_READ;
            end
        end
        else if (head_reg[1] == FN_WRITE_SINGLE)
        begin
            if ({1'b0, addr16} >= lim17)
            begin
                code_next = EXC_ADDR;
            end
            else if (!(attr_valid_reg && a_wr) || arg16 < a_low || arg16 > a_high)
            begin
                code_next = EXC_VALUE;
            end
            else
            begin
                kind_next = RK_WRITE;
            end
        end
    end

    assign hdr_len = (kind_reg == RK_WRITE) ? 3'd6 : 3'd3;

    assign status.silent    = count_reg < 4'd4 || head_reg[0] != slave_addr_reg
                           || crc_reg != 16'd0;
    assign status.is_read   = kind_reg == RK_READ;
    assign status.hdr_last  = hdr_ptr_reg == hdr_len - 3'd1;
    assign status.regs_last = reg_ptr_reg == nregs - 5'd1;

    always_comb
    begin
        hdr_byte = head_reg[0];
        unique case (kind_reg)
            RK_EXC:
            begin
                if (hdr_ptr_reg == 3'd1)
                begin
                    hdr_byte = head_reg[1] | FN_EXC_FLAG;
                end
                else if (hdr_ptr_reg == 3'd2)
                begin
                    hdr_byte = code_reg;
                end
            end
            RK_READ:
            begin
                if (hdr_ptr_reg == 3'd1)
                begin
                    hdr_byte = FN_READ_HOLDING;
                end
                else if (hdr_ptr_reg == 3'd2)
                begin
                    hdr_byte = {2'b00, nregs, 1'b0};
                end
            end
            RK_WRITE: hdr_byte = head_reg[hdr_ptr_reg];
            default:  hdr_byte = head_reg[0];
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit_hdr)
            tx_byte = hdr_byte;
        else if (cmd.emit_hi)
            tx_byte = val_rdata[15:8];
        else if (cmd.emit_lo)
            tx_byte = val_rdata[7:0];
        else if (cmd.emit_crc_lo)
            tx_byte = tx_crc_reg[7:0];
        else if (cmd.emit_crc_hi)
            tx_byte = tx_crc_reg[15:8];
        else
            tx_byte = 8'h00;
    end

    assign rsp.kind      = cmd.emit_host;
    assign rsp.tx_byte   = cmd.emit_host ? 8'h00 : tx_byte;
    assign rsp.tx_last   = cmd.emit_crc_hi;
    assign rsp.value_out = (cmd.emit_host && !host_oob_reg) ? val_rdata : 16'h0000;

    // value ram ports
    assign rd_off    = cmd.emit_lo ? AW'(reg_ptr_reg + 5'd1) : '0;
    assign val_re    = cmd.host_rd || (cmd.emit_hdr && status.hdr_last && status.is_read)
                    || (cmd.emit_lo && !status.regs_last);
    assign val_raddr = cmd.host_rd ? idx_a : addr_a + rd_off;
    assign val_we    = (cmd.load && idx_ok) || (cmd.decide && kind_next == RK_WRITE);
    assign val_waddr = cmd.load ? idx_a : addr_a;
    assign val_wdata = cmd.load ? req.entry_value : arg16;

    mrs_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH), .ADDR_W(AW)) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    mrs_ram #(.WIDTH(ATTR_W), .DEPTH(TABLE_DEPTH), .ADDR_W(AW)) u_attrs (
        .clk   (clk),
        .we    (cmd.load && idx_ok),
        .waddr (idx_a),
        .wdata ({req.entry_readable, req.entry_writable, req.entry_low, req.entry_high}),
        .re    (cmd.attr_rd),
        .raddr (addr_a),
        .rdata (attr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd1;
            entries_reg    <= 7'd64;
            count_reg      <= 4'd0;
            crc_reg        <= CRC_INIT;
            valid_reg      <= '0;
            kind_reg       <= RK_EXC;
            hdr_ptr_reg    <= 3'd0;
            reg_ptr_reg    <= 5'd0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_SLAVE_ADDR)
            begin
                slave_addr_reg <= cfg_data & BYTE_MASK;
            end
            if (cfg_we && cfg_index == CFG_ENTRIES)
            begin
                entries_reg <= cfg_data[6:0];
            end
            if (cmd.clear_frame)
            begin
                count_reg <= 4'd0;
                crc_reg   <= CRC_INIT;
            end
            else if (cmd.frame_byte)
            begin
                if (count_reg != 4'd15)
                begin
                    count_reg <= count_reg + 4'd1;
                end
                crc_reg <= crc_feed(crc_reg, req.rx_byte);
            end
            if (cmd.load && idx_ok)
            begin
                valid_reg[idx_a] <= 1'b1;
            end
            if (cmd.decide)
            begin
                kind_reg    <= kind_next;
                hdr_ptr_reg <= 3'd0;
                reg_ptr_reg <= 5'd0;
            end
            else
            begin
                if (cmd.emit_hdr)
                begin
                    hdr_ptr_reg <= hdr_ptr_reg + 3'd1;
                end
                if (cmd.emit_lo)
                begin
                    reg_ptr_reg <= reg_ptr_reg + 5'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.clear_frame)
        begin
            for (int i = 0; i < 6; i++)
            begin
                head_reg[i] <= 8'h00;
            end
        end
        else if (cmd.frame_byte && count_reg < 4'd6)
        begin
            head_reg[count_reg[2:0]] <= req.rx_byte;
        end
        if (cmd.attr_rd)
        begin
            attr_valid_reg <= valid_reg[addr_a];
        end
        if (cmd.host_rd)
        begin
            host_oob_reg <= !idx_ok;
        end
        if (cmd.decide)
        begin
            code_reg   <= code_next;
            tx_crc_reg <= CRC_INIT;
        end
        else if (cmd.emit_hdr || cmd.emit_hi || cmd.emit_lo)
        begin
            tx_crc_reg <= crc_feed(tx_crc_reg, tx_byte);
        end
    end

endmodule

/* design/modbus_rtu_register_slave_unit.sv */
// top level of the modbus rtu register slave: functions 3 and 6 over a register table
// frame bytes without frame end and table loads are taken without raising busy
// table value read: result in the cycle after the request, busy while it is shown
// frame end: a check state and a decide state, then one reply byte per cycle, the ram fetch of each
//   register overlapping the byte before it; busy lasts longest for a 29 register read
// reset clears control state and table entry valid flags; config returns to address 1, 64 entries
`include "modbus_rtu_register_slave_unit_defines.svh"
module modbus_rtu_register_slave_unit
    import mrs_pkg::*;
#(
    parameter int TABLE_DEPTH = MRS_TABLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request side
    input  logic                      start,
    output logic                      busy,
    input  mrs_req_t                  request,
    // result side, one strobe per reply byte or table value
    output logic                      result_valid,
    output mrs_rsp_t                  result,
    // configuration writes
    input  logic                      cfg_we,
    input  logic [MRS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [MRS_CFG_DATA_W-1:0] cfg_data
);

    mrs_cmd_t    cmd;
    mrs_status_t status;

    // sequencer: owns the state machine, decides which datapath step runs
    mrs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (request.op),
        .frame_end    (request.frame_end),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    // datapath: frame crc and header capture, table rams, reply byte generation
    mrs_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .rsp       (result)
    );

    // results only appear while a request is being worked on
    `MRS_ASSERT_SAME(a_result_busy, result_valid, busy, "result outside busy window")
    // a table value request answers in the following cycle
    `MRS_ASSERT_NEXT(a_host_read, start && !busy && request.op == OP_READ, result_valid && result.kind, "table value not returned")
    // the final crc byte of a reply frees the block
    `MRS_ASSERT_NEXT(a_last_idle, result_valid && result.tx_last, !busy, "still busy after reply end")
    // table values never carry the end-of-reply mark
    `MRS_ASSERT_SAME(a_kind_last, result_valid && result.kind, !result.tx_last, "tx_last on table value")

endmodule

/* tb/modbus_rtu_register_slave_unit_checker.sv */
// checker for the modbus rtu register slave: watches requests, config writes and results
module modbus_rtu_register_slave_unit_checker
    import mrs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  mrs_req_t                  request,
    input  logic                      result_valid,
    input  mrs_rsp_t                  result,
    input  logic                      cfg_we,
    input  logic [MRS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [MRS_CFG_DATA_W-1:0] cfg_data,
    output int                        failures,
    output int                        pending,
    output int                        checked
);

    logic [7:0]  station;
    logic [6:0]  entries;
    logic [3:0]  rx_count;
    logic [7:0]  head [6];
    logic [15:0] rx_crc;
    logic [15:0] tbl_value [MRS_TABLE_DEPTH];
    logic [1:0]  tbl_flags [MRS_TABLE_DEPTH];
    logic [15:0] tbl_low [MRS_TABLE_DEPTH];
    logic [15:0] tbl_high [MRS_TABLE_DEPTH];
    mrs_rsp_t    reply_q [$];

    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void frame_clear();
        rx_count = '0;
        rx_crc = CRC_INIT;
        foreach (head[i])
        begin
            head[i] = '0;
        end
    endfunction

    // reply bytes for the frame held in head, then crc and queueing
    function automatic void answer_frame();
        logic [7:0]  rep [$];
        logic [15:0] c;
        int          lim;
        int          addr;
        int          arg;
        mrs_rsp_t    r;
        lim  = (entries < MRS_TABLE_DEPTH) ? entries : MRS_TABLE_DEPTH;
        addr = {head[2], head[3]};
        arg  = {head[4], head[5]};
        if (head[1] == FN_READ_HOLDING)
        begin
            if (addr >= lim)
                rep = '{head[0], head[1] | FN_EXC_FLAG, EXC_ADDR};
            else if (arg == 0 || arg > MRS_MAX_READ)
                rep = '{head[0], head[1] | FN_EXC_FLAG, EXC_VALUE};
            else if (addr + arg > lim)
                rep = '{head[0], head[1] | FN_EXC_FLAG, EXC_ADDR};
            else if (!tbl_flags[addr][0])
                rep = '{head[0], head[1] | FN_EXC_FLAG, EXC_VALUE};
            else
            begin
                rep = '{head[0], FN_READ_HOLDING, 8'(2 * arg)};
                for (int i = 0; i < arg; i++)
                begin
                    rep.push_back(tbl_value[addr + i][15:8]);
                    rep.push_back(tbl_value[addr + i][7:0]);
                end
            end
        end
        else if (head[1] == FN_WRITE_SINGLE)
        begin
            if (addr >= lim)
                rep = '{head[0], head[1] | FN_EXC_FLAG, EXC_ADDR};
            else if (!tbl_flags[addr][1] || arg < tbl_low[addr] || arg > tbl_high[addr])
                rep = '{head[0], head[1] | FN_EXC_FLAG, EXC_VALUE};
            else
            begin
                tbl_value[addr] = 16'(arg);
                rep = '{head[0], head[1], head[2], head[3], head[4], head[5]};
            end
        end
        else
            rep = '{head[0], head[1] | FN_EXC_FLAG, EXC_FUNC};
        c = CRC_INIT;
        foreach (rep[i])
        begin
            c = crc_update(c, rep[i]);
        end
        rep.push_back(c[7:0]);
        rep.push_back(c[15:8]);
        foreach (rep[i])
        begin
            r = '0;
            r.tx_byte = rep[i];
            r.tx_last = (i == rep.size() - 1);
            reply_q.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mrs_rsp_t e;
        if (!rst_n)
        begin
            station = 8'd1;
            entries = 7'd64;
            frame_clear();
            foreach (tbl_flags[i])
            begin
                tbl_flags[i] = '0;
                tbl_value[i] = '0;
                tbl_low[i] = '0;
                tbl_high[i] = '0;
            end
            reply_q.delete();
            failures = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            // results first: none can stem from a request accepted at this same edge
            if (result_valid)
            begin
                checked++;
                if (reply_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result kind=%0d byte=%02h last=%0d value=%04h",
                             $time, result.kind, result.tx_byte, result.tx_last,
                             result.value_out);
                end
                else
                begin
                    e = reply_q.pop_front();
                    if (result !== e)
                    begin
                        failures++;
                        $display("%0t: expected kind=%0d byte=%02h last=%0d value=%04h, %s",
                                 $time, e.kind, e.tx_byte, e.tx_last, e.value_out,
                                 $sformatf("got kind=%0d byte=%02h last=%0d value=%04h",
                                           result.kind, result.tx_byte, result.tx_last,
                                           result.value_out));
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_SLAVE_ADDR)
                    station = cfg_data;
                else if (cfg_index == CFG_ENTRIES)
                    entries = cfg_data[6:0];
            end
            if (start && !busy)
            begin
                if (request.op == OP_LOAD)
                begin
                    tbl_value[request.entry_index] = request.entry_value;
                    tbl_flags[request.entry_index] = {request.entry_writable,
                                                      request.entry_readable};
                    tbl_low[request.entry_index]  = request.entry_low;
                    tbl_high[request.entry_index] = request.entry_high;
                end
                else if (request.op == OP_READ)
                begin
                    e = '0;
                    e.kind = 1'b1;
                    e.value_out = tbl_value[request.entry_index];
                    reply_q.push_back(e);
                end
                else if (request.op == OP_FRAME)
                begin
                    if (rx_count < 6)
                        head[rx_count] = request.rx_byte;
                    if (rx_count < 15)
                        rx_count++;
                    rx_crc = crc_update(rx_crc, request.rx_byte);
                    if (request.frame_end)
                    begin
                        if (rx_count >= 4 && head[0] == station && rx_crc == 16'h0000)
                            answer_frame();
                        frame_clear();
                    end
                end
            end
            pending = reply_q.size();
        end
    end

endmodule

/* tb/modbus_rtu_register_slave_unit_test.sv */
// stimulus and verdict for the modbus rtu register slave
module modbus_rtu_register_slave_unit_test;
    import mrs_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    mrs_req_t                  request;
    logic                      result_valid;
    mrs_rsp_t                  result;
    logic                      cfg_we;
    logic [MRS_CFG_IDX_W-1:0]  cfg_index;
    logic [MRS_CFG_DATA_W-1:0] cfg_data;
    int                        failures;
    int                        pending;
    int                        checked;

    // stimulus-side view of the block, enough to aim requests at interesting cases
    logic [7:0]  station;
    int          limit;
    int          idle_pct;
    int          requests_sent;
    int          frames_sent;
    logic [15:0] lo_of [MRS_TABLE_DEPTH];
    logic [15:0] hi_of [MRS_TABLE_DEPTH];

    modbus_rtu_register_slave_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    modbus_rtu_register_slave_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #6000000;
        $display("FAILED: results differ");
        $finish;
    end

    // hand one request over, hold until accepted, then maybe leave a gap
    task automatic issue(input mrs_req_t r);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        requests_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // wait until every expected result is in, plus room for a silent frame still in work
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [MRS_CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SLAVE_ADDR)
            station = val;
        else
            limit = (val[6:0] < MRS_TABLE_DEPTH) ? val[6:0] : MRS_TABLE_DEPTH;
    endtask

    task automatic load(input int idx, input logic [15:0] val, input logic rd, input logic wr,
                        input logic [15:0] lo, input logic [15:0] hi);
        mrs_req_t r;
        r = mrs_req_t'({$urandom, $urandom});
        r.op = OP_LOAD;
        r.entry_index = 6'(idx);
        r.entry_value = val;
        r.entry_readable = rd;
        r.entry_writable = wr;
        r.entry_low = lo;
        r.entry_high = hi;
        lo_of[idx] = lo;
        hi_of[idx] = hi;
        issue(r);
    endtask

    task automatic host_read(input int idx);
        mrs_req_t r;
        r = mrs_req_t'({$urandom, $urandom});
        r.op = OP_READ;
        r.entry_index = 6'(idx);
        issue(r);
    endtask

    // frame bytes with a crc appended; the crc can be spoilt to make a silent frame
    task automatic send_frame(input logic [7:0] body [$], input bit spoil_crc);
        logic [15:0] c;
        mrs_req_t    r;
        c = CRC_INIT;
        foreach (body[i])
        begin
            c = crc_feed(c, body[i]);
        end
        if (spoil_crc)
            c ^= 16'(1 << $urandom_range(15));
        body.push_back(c[7:0]);
        body.push_back(c[15:8]);
        foreach (body[i])
        begin
            r = mrs_req_t'({$urandom, $urandom});
            r.op = OP_FRAME;
            r.rx_byte = body[i];
            r.frame_end = (i == body.size() - 1);
            issue(r);
        end
        frames_sent++;
    endtask

    task automatic modbus(input logic [7:0] a, input logic [7:0] fn, input logic [15:0] p1,
                          input logic [15:0] p2);
        send_frame('{a, fn, p1[15:8], p1[7:0], p2[15:8], p2[7:0]}, 1'b0);
    endtask

    // one random request or frame, mostly well-formed traffic with random content
    task automatic random_traffic();
        int          sel;
        int          addr;
        int          cnt;
        logic [7:0]  a;
        logic [7:0]  body [$];
        mrs_req_t    r;
        sel  = $urandom_range(99);
        a    = ($urandom_range(99) < 85) ? station : 8'($urandom);
        addr = (limit > 0 && $urandom_range(9) < 8) ? $urandom_range(limit - 1)
                                                     : $urandom_range(70);
        if (sel < 8)
            load($urandom_range(63), 16'($urandom), $urandom_range(3) != 0,
                 $urandom_range(3) != 0, 16'($urandom_range(32767)),
                 16'($urandom_range(65535, 16384)));
        else if (sel < 15)
            host_read($urandom_range(63));
        else if (sel < 17)
        begin
            // unknown host op, ignored by the block
            r = mrs_req_t'({$urandom, $urandom});
            r.op = 2'd3;
            issue(r);
        end
        else if (sel < 27)
        begin
            // broken frames: short, spoilt crc or random junk
            repeat ($urandom_range(1, 9)) body.push_back(8'($urandom));
            body[0] = a;
            send_frame(body, $urandom_range(1) != 0 || body.size() < 2);
        end
        else if (sel < 60)
        begin
            cnt = (limit > addr && $urandom_range(9) < 8)
                  ? $urandom_range(1, (limit - addr < MRS_MAX_READ) ? limit - addr
                                                                     : MRS_MAX_READ)
                  : $urandom_range(32);
            modbus(a, FN_READ_HOLDING, 16'(addr), 16'(cnt));
        end
        else if (sel < 90)
            modbus(a, FN_WRITE_SINGLE, 16'(addr),
                   (addr < MRS_TABLE_DEPTH && $urandom_range(1) &&
                    lo_of[addr] <= hi_of[addr])
                   ? 16'($urandom_range(hi_of[addr], lo_of[addr])) : 16'($urandom));
        else
            modbus(a, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic [7:0] settings_addr [4] = '{8'hFF, 8'h00, 8'h3C, 8'hA5};
        logic [7:0] settings_ent  [4] = '{8'd64, 8'd17, 8'd0, 8'd100};
        int         phase_pct     [4] = '{35, 67, 0, 35};
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SLAVE_ADDR;
        cfg_data = '0;
        station = 8'd1;
        limit = MRS_TABLE_DEPTH;
        idle_pct = 35;
        requests_sent = 0;
        frames_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_cfg(CFG_SLAVE_ADDR, 8'd1);
        write_cfg(CFG_ENTRIES, 8'd64);

        // table fill so no read ever touches an unwritten entry
        for (int i = 0; i < MRS_TABLE_DEPTH; i++)
        begin
            load(i, 16'($urandom), i != 5, i != 6, 16'h0000, 16'hFFFF);
        end
        load(7, 16'h0150, 1'b1, 1'b1, 16'h0100, 16'h0200);
        load(63, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 16'hFFFF);

        // directed: every reply path and the silent frames
        modbus(8'd1, FN_READ_HOLDING, 16'd0, 16'd29);       // longest read
        modbus(8'd1, FN_READ_HOLDING, 16'd63, 16'd1);
        modbus(8'd1, FN_READ_HOLDING, 16'd64, 16'd1);       // start beyond table
        modbus(8'd1, FN_READ_HOLDING, 16'd0, 16'd0);        // zero count
        modbus(8'd1, FN_READ_HOLDING, 16'd0, 16'd30);       // count above the maximum
        modbus(8'd1, FN_READ_HOLDING, 16'd50, 16'd20);      // runs off the end
        modbus(8'd1, FN_READ_HOLDING, 16'd5, 16'd2);        // not readable
        modbus(8'd1, FN_WRITE_SINGLE, 16'd7, 16'h0180);     // in range
        modbus(8'd1, FN_WRITE_SINGLE, 16'd7, 16'h00FF);     // below low
        modbus(8'd1, FN_WRITE_SINGLE, 16'd7, 16'h0201);     // above high
        modbus(8'd1, FN_WRITE_SINGLE, 16'd6, 16'h0000);     // not writable
        modbus(8'd1, FN_WRITE_SINGLE, 16'hFFFF, 16'h0000);  // address far out
        modbus(8'd1, 8'h10, 16'd0, 16'd1);                  // unsupported function
        modbus(8'd2, FN_READ_HOLDING, 16'd0, 16'd1);        // other station
        send_frame('{8'd1, FN_READ_HOLDING, 8'd0, 8'd0, 8'd0, 8'd1}, 1'b1);
        send_frame('{8'd1}, 1'b0);                          // three bytes only
        send_frame('{8'd1, 8'h2B}, 1'b0);                   // four bytes, header short
        send_frame('{8'd1, FN_WRITE_SINGLE, 8'd0, 8'd7, 8'h01, 8'h90,
                     8'hAA, 8'h55, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b0);
        host_read(7);
        host_read(63);
        settle();

        // random phases across address and table-size settings, extremes included
        for (int p = 0; p < 4; p++)
        begin
            write_cfg(CFG_SLAVE_ADDR, settings_addr[p]);
            write_cfg(CFG_ENTRIES, settings_ent[p]);
            idle_pct = phase_pct[p];
            for (int n = requests_sent; requests_sent < n + 24; )
            begin
                random_traffic();
                // sometimes hold off until the block has answered everything
                if ($urandom_range(99) < 4)
                    settle();
            end
            settle();
        end

        $display("%0d requests in %0d frames and host ops over 5 settings, %0d results checked",
                 requests_sent, frames_sent, checked);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/mrs_pkg.sv
design/mrs_ram.sv
design/mrs_ctrl.sv
design/mrs_dp.sv
design/modbus_rtu_register_slave_unit.sv
tb/modbus_rtu_register_slave_unit_checker.sv
tb/modbus_rtu_register_slave_unit_test.sv
